/* rtl/ecal_pkg.sv */
package ecal_pkg;

    // Field and internal widths
    localparam int unsigned SEC_W  = 38;
    localparam int unsigned DAYS_W = 22;
    localparam int unsigned SOD_W  = 17;
    localparam int unsigned YEAR_W = 14;
    localparam int unsigned YS_W   = 22;
    localparam int unsigned YDAY_W = 9;
    localparam int unsigned CNT_W  = 1;

    // First second of year 10000
    localparam logic [SEC_W-1:0] LIMIT_SECONDS = 38'd253402300800;
    localparam logic [16:0]      SECS_PER_DAY  = 17'd86400;

    // First step of the day division: the quotient comes at step one, the second
    // of day and the weekday at step zero.
    localparam logic [CNT_W-1:0] DIV_LAST = 1'b1;

    localparam logic [YEAR_W-1:0] BASE_YEAR = 14'd1970;
    localparam logic [YEAR_W-1:0] LAST_YEAR = 14'd9999;

    // Reciprocals, each scaled by a power of two
    localparam logic [31:0] DAY_RECIP  = 32'd3257812231; // 2^41 / 675, rounded up
    localparam logic [22:0] WEEK_RECIP = 23'd4793491;    // 2^25 / 7, rounded up
    localparam logic [11:0] YEAR_RECIP = 12'd2871;   // 2^20 / 365.2425, rounded up
    localparam logic [16:0] MIN_RECIP  = 17'd69905;  // 2^22 / 60, rounded down
    localparam logic [10:0] HOUR_RECIP = 11'd1092;   // 2^16 / 60, rounded down
    localparam logic [12:0] C100_RECIP = 13'd5243;   // 2^19 / 100, rounded up

    // Leap days in years 1 to 1969
    localparam logic [YS_W-1:0] LEAPS_BASE = 22'd477;

    // Controller states
    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_DIV  = 10'b0000000010,
        S_EST  = 10'b0000000100,
        S_MIN  = 10'b0000001000,
        S_HEST = 10'b0000010000,
        S_HRS  = 10'b0000100000,
        S_DOWN = 10'b0001000000,
        S_UP   = 10'b0010000000,
        S_YDAY = 10'b0100000000,
        S_FIN  = 10'b1000000000
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic             load;
        logic             div_step;
        logic [CNT_W-1:0] div_idx;
        logic             est;
        logic             min_fix;
        logic             hour_est;
        logic             hour_fix;
        logic             ys_next;
        logic             year_dec;
        logic             year_inc;
        logic             yday;
        logic             fin;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic range_err;
        logic dn_go;
        logic up_go;
    } sts_t;

    typedef struct packed {
        logic              range_error;
        logic [2:0]        weekday;
        logic [5:0]        second;
        logic [5:0]        minute;
        logic [4:0]        hour;
        logic [YDAY_W-1:0] day_of_year;
        logic [4:0]        day_of_month;
        logic [3:0]        month;
        logic [YEAR_W-1:0] year;
    } result_t;

    // Days before the first of month m (zero-based), with the leap day after February.
    function automatic logic [YDAY_W-1:0] cum_days(input logic leap, input logic [3:0] m);
        logic [YDAY_W-1:0] v;
        case (m)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd59;
            4'd3:    v = 9'd90;
            4'd4:    v = 9'd120;
            4'd5:    v = 9'd151;
            4'd6:    v = 9'd181;
            4'd7:    v = 9'd212;
            4'd8:    v = 9'd243;
            4'd9:    v = 9'd273;
            4'd10:   v = 9'd304;
            4'd11:   v = 9'd334;
            default: v = 9'd0;
        endcase
        if (m >= 4'd2) begin
            v = v + 9'(leap);
        end
        return v;
    endfunction

    // Days from 1970-01-01 to January 1 of year y, for y from 1970 to 10000.
    function automatic logic [YS_W-1:0] year_start(input logic [YEAR_W-1:0] y);
        logic [YEAR_W-1:0] p;
        logic [26:0]       c_prod;
        logic [6:0]        c100;
        logic [12:0]       off;
        logic [YS_W-1:0]   base;
        p      = y - 14'd1;
        c_prod = 27'(p) * 27'(C100_RECIP);
        c100   = c_prod[25:19];
        off    = 13'(y - BASE_YEAR);
        base   = 22'(off) * 22'd365;
        return base + 22'(p[YEAR_W-1:2]) - 22'(c100) + 22'(c100[6:2]) - LEAPS_BASE;
    endfunction

endpackage

/* rtl/epoch_seconds_to_calendar.sv */
// Converts a count of seconds since 1970-01-01 00:00:00 UTC into the Gregorian
// calendar date and time of day.
// Input channel (s_): one transfer carries epoch_seconds in s_tdata[37:0].
// Result channel (m_): one transfer per input carries year, month, day of month,
// day of year, hour, minute, second and weekday in m_tdata, and the range error
// flag in m_tuser. Inputs from the first second of year 10000 on give the flag
// and all-zero date fields.
// Order of work from the input transfer to m_tvalid for a valid time: day
// division by reciprocal multiplication, the time of day, year stepping, the day
// of year, then the month and result write. On error the result write follows
// the day division directly.
// Throughput: one item at a time; the next input is taken in the cycle after the
// result is written. The number of year steps varies with the input, so items
// differ in how long they take.
// When the receiver stalls, the result stays in the output register and the
// block may take and work on one more item, then waits until the register frees.
// Reset (aresetn low, synchronous) returns the sequencer to idle and empties the
// output register; an item in flight is dropped.
module epoch_seconds_to_calendar (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [37:0] epoch_seconds, [39:38] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [13:0] year, [17:14] month, [22:18] day_of_month,
                                   // [31:23] day_of_year, [36:32] hour, [42:37] minute,
                                   // [48:43] second, [51:49] weekday, [55:52] zero
    output logic        m_tuser    // [0] range_error
);

    ecal_pkg::cmd_t    cmd;
    ecal_pkg::sts_t    sts;
    ecal_pkg::result_t result;

    ecal_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ecal_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .epoch_seconds (s_tdata[ecal_pkg::SEC_W-1:0]),
        .sts           (sts),
        .result        (result)
    );

    // Pack the result fields, highest field first, year in the lowest bits.
    assign m_tdata = {4'b0000, result.weekday, result.second, result.minute, result.hour,
                      result.day_of_year, result.day_of_month, result.month, result.year};
    assign m_tuser = result.range_error;

endmodule

/* rtl/ecal_ctrl.sv */
module ecal_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  ecal_pkg::sts_t   sts,
    output ecal_pkg::cmd_t   cmd
);

    ecal_pkg::state_t               state_reg, state_next;
    logic [ecal_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic                           out_valid_reg, out_valid_next;

    // Sequencer: day division, time of day, years, day of year, result write.
    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        cmd         = '0;
        cmd.div_idx = cnt_reg;
        case (state_reg)
            ecal_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    cnt_next   = ecal_pkg::DIV_LAST;
                    state_next = ecal_pkg::S_DIV;
                end
            end
            ecal_pkg::S_DIV: begin
                if (sts.range_err) begin
                    state_next = ecal_pkg::S_FIN;
                end else begin
                    cmd.div_step = 1'b1;
                    if (cnt_reg == '0) begin
                        state_next = ecal_pkg::S_EST;
                    end else begin
                        cnt_next = cnt_reg - 1'b1;
                    end
                end
            end
            ecal_pkg::S_EST: begin
                cmd.est    = 1'b1;
                state_next = ecal_pkg::S_MIN;
            end
            ecal_pkg::S_MIN: begin
                cmd.min_fix = 1'b1;
                state_next  = ecal_pkg::S_HEST;
            end
            ecal_pkg::S_HEST: begin
                cmd.hour_est = 1'b1;
                state_next   = ecal_pkg::S_HRS;
            end
            ecal_pkg::S_HRS: begin
                cmd.hour_fix = 1'b1;
                state_next   = ecal_pkg::S_DOWN;
            end
            ecal_pkg::S_DOWN: begin
                if (sts.dn_go) begin
                    cmd.year_dec = 1'b1;
                end else begin
                    state_next = ecal_pkg::S_UP;
                end
            end
            ecal_pkg::S_UP: begin
                cmd.ys_next = 1'b1;
                if (sts.up_go) begin
                    cmd.year_inc = 1'b1;
                end else begin
                    state_next = ecal_pkg::S_YDAY;
                end
            end
            ecal_pkg::S_YDAY: begin
                cmd.yday   = 1'b1;
                state_next = ecal_pkg::S_FIN;
            end
            ecal_pkg::S_FIN: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.fin    = 1'b1;
                    state_next = ecal_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = ecal_pkg::S_IDLE;
            end
        endcase
    end

    // The output register is full from a result write until its transfer.
    always_comb begin
        if (cmd.fin) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ecal_pkg::S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ecal_pkg::S_IDLE);
    assign m_tvalid = out_valid_reg;

`ifndef SYNTHESIS
    a_fin_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fin |-> (!out_valid_reg || m_tready))
        else $error("result written over an untaken result");
    a_load_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ecal_pkg::S_DIV))
        else $error("accepted item did not start the day division");
    a_inc_stay: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.year_inc |=> (state_reg == ecal_pkg::S_UP))
        else $error("year increment left the upward stepping state");
`endif

endmodule

/* rtl/ecal_dp.sv */
module ecal_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ecal_pkg::cmd_t                cmd,
    input  logic [ecal_pkg::SEC_W-1:0]    epoch_seconds,
    output ecal_pkg::sts_t                sts,
    output ecal_pkg::result_t             result
);

    logic [ecal_pkg::SEC_W-1:0]  rem_reg, rem_next;
    logic [ecal_pkg::DAYS_W-1:0] days_reg;
    logic [2:0]                  wk_reg, wk_next;
    logic                        err_reg;
    logic [10:0]                 min_reg;
    logic [5:0]                  sec_reg;
    logic [5:0]                  minute_reg;
    logic [4:0]                  hour_reg;
    logic [ecal_pkg::YEAR_W-1:0] year_reg, year_next;
    logic [ecal_pkg::YS_W-1:0]   ys_hi_reg;
    logic [ecal_pkg::YDAY_W-1:0] yday_reg, yday_next;
    logic                        leap_reg, leap_next;
    ecal_pkg::result_t           result_reg, result_next;

    logic [30:0]                 sec_hi;
    logic [62:0]                 day_prod;
    logic [ecal_pkg::DAYS_W-1:0] day_quot;
    logic [ecal_pkg::SEC_W-1:0]  day_secs;
    logic [44:0]                 wk_prod;
    logic [ecal_pkg::DAYS_W-1:0] wk_rem;
    logic [ecal_pkg::SOD_W-1:0]  sod;
    logic [33:0]                 year_prod;
    logic [14:0]                 year_sum;
    logic [33:0]                 min_prod;
    logic [ecal_pkg::SOD_W-1:0]  min_rem;
    logic [21:0]                 hour_prod;
    logic [10:0]                 hour_rem;
    logic [ecal_pkg::YEAR_W-1:0] ys_arg;
    logic [ecal_pkg::YS_W-1:0]   ys;
    logic [ecal_pkg::YS_W-1:0]   yday_full;
    logic [3:0]                  mon_idx;
    logic [ecal_pkg::YDAY_W-1:0] mon_base;
    logic [ecal_pkg::YDAY_W-1:0] dom_full;
    logic [3:0]                  wk_plus;

    // Day division by reciprocal multiplication. The day length is 675 * 2^7, so
    // the seconds shifted down by seven are divided by 675 in the first step. The
    // second step forms the second of day and the day count modulo 7.
    always_comb begin
        sec_hi   = rem_reg[ecal_pkg::SEC_W-1:7];
        day_prod = 63'(sec_hi) * 63'(ecal_pkg::DAY_RECIP);
        day_quot = day_prod[62:41];
        day_secs = 38'(days_reg) * 38'(ecal_pkg::SECS_PER_DAY);
        rem_next = rem_reg - day_secs;
        wk_prod  = 45'(days_reg) * 45'(ecal_pkg::WEEK_RECIP);
        wk_rem   = days_reg - 22'(wk_prod[44:25]) * 22'd7;
        wk_next  = wk_rem[2:0];
    end

    assign sod = rem_reg[ecal_pkg::SOD_W-1:0];

    // Year, minute and hour estimates by reciprocal multiplication.
    always_comb begin
        year_prod = 34'(days_reg) * 34'(ecal_pkg::YEAR_RECIP);
        year_sum  = 15'(ecal_pkg::BASE_YEAR) + 15'(year_prod[33:20]);
        min_prod  = 34'(sod) * 34'(ecal_pkg::MIN_RECIP);
        hour_prod = 22'(min_reg) * 22'(ecal_pkg::HOUR_RECIP);
    end

    // Remainders after the estimates; each estimate is low by at most one.
    assign min_rem  = sod - (17'(min_reg) << 6) + (17'(min_reg) << 2);
    assign hour_rem = min_reg - (11'(hour_reg) << 6) + (11'(hour_reg) << 2);

    // Start of the year under test, or of the year after it while stepping up.
    assign ys_arg = cmd.ys_next ? (year_reg + 14'd1) : year_reg;
    assign ys     = ecal_pkg::year_start(ys_arg);

    assign sts.range_err = err_reg;
    assign sts.dn_go     = (year_reg > ecal_pkg::BASE_YEAR) && (ys > days_reg);
    assign sts.up_go     = (year_reg < ecal_pkg::LAST_YEAR) && (ys <= days_reg);

    always_comb begin
        year_next = year_reg;
        if (cmd.est) begin
            year_next = (year_sum > 15'(ecal_pkg::LAST_YEAR)) ? ecal_pkg::LAST_YEAR
                                                             : year_sum[ecal_pkg::YEAR_W-1:0];
        end else if (cmd.year_dec) begin
            year_next = year_reg - 14'd1;
        end else if (cmd.year_inc) begin
            year_next = year_reg + 14'd1;
        end
    end

    // Day of year, and leap year from the length of the year.
    assign yday_full = days_reg - ys;
    assign yday_next = yday_full[ecal_pkg::YDAY_W-1:0];
    assign leap_next = ((ys_hi_reg - ys) == 22'd366);

    // Month: the last month whose first day is not after the day of year.
    always_comb begin
        mon_idx = 4'd0;
        for (int m = 1; m < 12; m++) begin
            if (yday_reg >= ecal_pkg::cum_days(leap_reg, 4'(m))) begin
                mon_idx = 4'(m);
            end
        end
        mon_base = ecal_pkg::cum_days(leap_reg, mon_idx);
        dom_full = yday_reg - mon_base + 9'd1;
        wk_plus  = 4'(wk_reg) + 4'd4;
    end

    always_comb begin
        result_next = '0;
        if (err_reg) begin
            result_next.range_error = 1'b1;
        end else begin
            result_next.year         = year_reg;
            result_next.month        = mon_idx + 4'd1;
            result_next.day_of_month = dom_full[4:0];
            result_next.day_of_year  = yday_reg;
            result_next.hour         = hour_reg;
            result_next.minute       = minute_reg;
            result_next.second       = sec_reg;
            result_next.weekday      = (wk_plus >= 4'd7) ? 3'(wk_plus - 4'd7) : wk_plus[2:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            err_reg <= 1'b0;
        end else if (cmd.load) begin
            err_reg <= (epoch_seconds >= ecal_pkg::LIMIT_SECONDS);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rem_reg  <= epoch_seconds;
            days_reg <= '0;
            wk_reg   <= '0;
        end else if (cmd.div_step) begin
            if (cmd.div_idx == ecal_pkg::DIV_LAST) begin
                days_reg <= day_quot;
            end else begin
                rem_reg <= rem_next;
                wk_reg  <= wk_next;
            end
        end
        if (cmd.est) begin
            min_reg <= min_prod[32:22];
        end else if (cmd.min_fix && (min_rem >= 17'd60)) begin
            min_reg <= min_reg + 11'd1;
        end
        if (cmd.min_fix) begin
            sec_reg <= (min_rem >= 17'd60) ? 6'(min_rem - 17'd60) : min_rem[5:0];
        end
        if (cmd.hour_est) begin
            hour_reg <= hour_prod[20:16];
        end else if (cmd.hour_fix && (hour_rem >= 11'd60)) begin
            hour_reg <= hour_reg + 5'd1;
        end
        if (cmd.hour_fix) begin
            minute_reg <= (hour_rem >= 11'd60) ? 6'(hour_rem - 11'd60) : hour_rem[5:0];
        end
        year_reg <= year_next;
        if (cmd.ys_next) begin
            ys_hi_reg <= ys;
        end
        if (cmd.yday) begin
            yday_reg <= yday_next;
            leap_reg <= leap_next;
        end
        if (cmd.fin) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

`ifndef SYNTHESIS
    a_sod_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.div_step && (cmd.div_idx == '0)) |=> (rem_reg < 38'(ecal_pkg::SECS_PER_DAY)))
        else $error("day division left a remainder of a day or more");
    a_step_done: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.yday |-> !sts.dn_go)
        else $error("year start lies after the day count");
    a_year_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.fin && !err_reg) |=> ((result_reg.year >= ecal_pkg::BASE_YEAR) &&
            (result_reg.year <= ecal_pkg::LAST_YEAR) && (result_reg.month >= 4'd1) &&
            (result_reg.month <= 4'd12)))
        else $error("result year or month out of range");
`endif

endmodule
